@@ hw/rtl/gwwb_pkg.sv @@
// Package for the greedy word wrap row breaker.
// Holds the request and row types, character codes and the saturating add.
// No dependencies.
`default_nettype none

package gwwb_pkg;

  localparam int unsigned CODE_W  = 21;
  localparam int unsigned ADV_W   = 12;
  localparam int unsigned IDX_W   = 16;
  localparam int unsigned LEN_W   = 16;

  localparam logic [CODE_W-1:0] CHAR_NEWLINE = 21'd10;
  localparam logic [CODE_W-1:0] CHAR_SPACE   = 21'd32;
  localparam logic [LEN_W-1:0]  LEN_MAX      = 16'hFFFF;

  // Row records held between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic [ADV_W-1:0]  advance;
    logic              is_last;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_start;
    logic [IDX_W-1:0] row_end;
    logic             end_open;
    logic [LEN_W-1:0] row_length;
    logic             last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_start;
    logic [IDX_W-1:0] row_end;
    logic             end_open;
    logic [LEN_W-1:0] row_length;
  } row_t;

  // All rows caused by one request: row0 always present, row1 optional.
  typedef struct packed {
    row_t row0;
    logic has_row1;
    row_t row1;
  } rec_t;

  typedef struct packed {
    logic empty;
    logic full;
    rec_t head;
  } q_status_t;

  function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                               input logic [ADV_W-1:0] b);
    logic [LEN_W:0] sum;
    sum = {1'b0, a} + {{(LEN_W + 1 - ADV_W){1'b0}}, b};
    return sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gwwb_front.sv @@
// Front of the row breaker: takes requests, tracks the running row and word
// state, and builds one record of closed rows per request. Uses gwwb_pkg.
`default_nettype none

module gwwb_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire gwwb_pkg::in_item_t          in_item_i,
  input  wire logic                        full_i,
  input  wire logic                        cfg_valid_i,
  input  wire logic [gwwb_pkg::LEN_W-1:0]  cfg_data_i,
  output logic                             wr_en_o,
  output gwwb_pkg::rec_t                   wr_rec_o
);

  logic [gwwb_pkg::LEN_W-1:0] wrap_q, wrap_d;
  logic [gwwb_pkg::IDX_W-1:0] idx_q, idx_d;
  logic [gwwb_pkg::LEN_W-1:0] cur_q, cur_d;
  logic [gwwb_pkg::LEN_W-1:0] lbs_q, lbs_d;
  logic [gwwb_pkg::LEN_W-1:0] word_q, word_d;
  logic [gwwb_pkg::IDX_W-1:0] ls_q, ls_d;
  logic                       ls_v_q, ls_v_d;
  logic [gwwb_pkg::IDX_W-1:0] ws_q, ws_d;
  logic                       ws_v_q, ws_v_d;
  logic [gwwb_pkg::IDX_W-1:0] rs_q, rs_d;

  logic                       accept;
  logic                       is_nl, is_sp;
  logic [gwwb_pkg::IDX_W-1:0] idx_next;
  logic [gwwb_pkg::IDX_W-1:0] ws_eff;
  logic [gwwb_pkg::LEN_W-1:0] cur_add, word_add;
  logic                       overflow, forced;
  logic                       has_event;
  gwwb_pkg::row_t             ev_row, last_row;

  assign accept   = push_i && !full_i;
  assign is_nl    = (in_item_i.char_code == gwwb_pkg::CHAR_NEWLINE);
  assign is_sp    = (in_item_i.char_code == gwwb_pkg::CHAR_SPACE);
  assign idx_next = idx_q + 16'd1;
  assign ws_eff   = ws_v_q ? ws_q : idx_q;
  assign cur_add  = gwwb_pkg::sat_add(cur_q, in_item_i.advance);
  assign word_add = gwwb_pkg::sat_add(word_q, in_item_i.advance);
  assign overflow = (wrap_q != '0) && (cur_add > wrap_q);
  assign forced   = overflow && (word_add > wrap_q);

  always_comb begin
    rs_d      = rs_q;
    cur_d     = cur_q;
    lbs_d     = lbs_q;
    word_d    = word_q;
    ls_d      = ls_q;
    ls_v_d    = ls_v_q;
    ws_d      = ws_q;
    ws_v_d    = ws_v_q;
    idx_d     = idx_q;
    has_event = 1'b0;
    ev_row    = '{row_start: rs_q, row_end: idx_q, end_open: 1'b0, row_length: cur_q};

    if (is_nl) begin
      has_event = 1'b1;
      rs_d      = idx_next;
      cur_d     = '0;
      lbs_d     = '0;
      word_d    = '0;
      ls_v_d    = 1'b0;
      ws_v_d    = 1'b0;
    end else if (is_sp) begin
      ls_d   = idx_q;
      ls_v_d = 1'b1;
      lbs_d  = cur_q;
      cur_d  = cur_add;
      ws_v_d = 1'b0;
      word_d = '0;
    end else begin
      ws_d   = ws_eff;
      ws_v_d = 1'b1;
      cur_d  = cur_add;
      word_d = word_add;
      if (forced) begin
        // Break the word at the character that overflows.
        has_event         = 1'b1;
        ev_row.row_length = wrap_q;
        rs_d              = idx_q;
        cur_d             = {{(gwwb_pkg::LEN_W - gwwb_pkg::ADV_W){1'b0}}, in_item_i.advance};
        word_d            = {{(gwwb_pkg::LEN_W - gwwb_pkg::ADV_W){1'b0}}, in_item_i.advance};
        lbs_d             = '0;
        ws_d              = idx_q;
      end else if (overflow) begin
        // Move the whole word to the next row.
        has_event         = 1'b1;
        ev_row.row_end    = ls_v_q ? ls_q : ws_eff;
        ev_row.row_length = lbs_q;
        rs_d              = ws_eff;
        cur_d             = word_add;
        lbs_d             = '0;
      end
    end

    last_row = '{row_start: rs_d, row_end: idx_next, end_open: 1'b1, row_length: cur_d};

    if (in_item_i.is_last) begin
      idx_d  = '0;
      rs_d   = '0;
      cur_d  = '0;
      lbs_d  = '0;
      word_d = '0;
      ls_v_d = 1'b0;
      ws_v_d = 1'b0;
    end else begin
      idx_d = idx_next;
    end
  end

  always_comb begin
    wr_en_o           = accept && (has_event || in_item_i.is_last);
    wr_rec_o.row0     = has_event ? ev_row : last_row;
    wr_rec_o.has_row1 = has_event && in_item_i.is_last;
    wr_rec_o.row1     = last_row;
  end

  assign wrap_d = cfg_valid_i ? cfg_data_i : wrap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= '0;
      idx_q  <= '0;
      rs_q   <= '0;
      cur_q  <= '0;
      lbs_q  <= '0;
      word_q <= '0;
      ls_q   <= '0;
      ls_v_q <= 1'b0;
      ws_q   <= '0;
      ws_v_q <= 1'b0;
    end else begin
      wrap_q <= wrap_d;
      if (accept) begin
        idx_q  <= idx_d;
        rs_q   <= rs_d;
        cur_q  <= cur_d;
        lbs_q  <= lbs_d;
        word_q <= word_d;
        ls_q   <= ls_d;
        ls_v_q <= ls_v_d;
        ws_q   <= ws_d;
        ws_v_q <= ws_v_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gwwb_queue.sv @@
// Short record queue between the front and the back of the row breaker.
// Register based FIFO of gwwb_pkg::rec_t entries.
`default_nettype none

module gwwb_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire gwwb_pkg::rec_t  wr_rec_i,
  input  wire logic            rd_en_i,
  output gwwb_pkg::q_status_t  status_o
);

  gwwb_pkg::rec_t              entry_q [gwwb_pkg::QUEUE_DEPTH];
  logic [gwwb_pkg::QPTR_W-1:0] wptr_q, wptr_d;
  logic [gwwb_pkg::QPTR_W-1:0] rptr_q, rptr_d;
  logic [gwwb_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        do_wr, do_rd;

  assign status_o.empty = (cnt_q == '0);
  assign status_o.full  = (cnt_q == gwwb_pkg::QCNT_W'(gwwb_pkg::QUEUE_DEPTH));
  assign status_o.head  = entry_q[rptr_q];

  assign do_wr  = wr_en_i && !status_o.full;
  assign do_rd  = rd_en_i && !status_o.empty;
  assign wptr_d = do_wr ? gwwb_pkg::QPTR_W'(wptr_q + 1'b1) : wptr_q;
  assign rptr_d = do_rd ? gwwb_pkg::QPTR_W'(rptr_q + 1'b1) : rptr_q;

  always_comb begin
    cnt_d = cnt_q;
    case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      entry_q[wptr_q] <= wr_rec_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gwwb_back.sv @@
// Back of the row breaker: hands out the rows of the head record one per pop
// and retires the record after its last row. Uses gwwb_pkg.
`default_nettype none

module gwwb_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire gwwb_pkg::q_status_t  status_i,
  input  wire logic                 pop_i,
  output logic                      rd_en_o,
  output logic                      empty_o,
  output gwwb_pkg::out_item_t       out_item_o
);

  logic           sel_q, sel_d;
  logic           at_last;
  logic           taken;
  gwwb_pkg::row_t shown;

  assign shown   = sel_q ? status_i.head.row1 : status_i.head.row0;
  assign at_last = sel_q || !status_i.head.has_row1;
  assign taken   = pop_i && !status_i.empty;
  assign rd_en_o = taken && at_last;
  assign empty_o = status_i.empty;

  always_comb begin
    out_item_o.row_start   = shown.row_start;
    out_item_o.row_end     = shown.row_end;
    out_item_o.end_open    = shown.end_open;
    out_item_o.row_length  = shown.row_length;
    out_item_o.last_of_run = at_last;
  end

  // Advance to the second row, or drop back to the first when the record retires.
  assign sel_d = taken ? !at_last : sel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/greedy_word_wrap_breaker.sv @@
// Top level of the greedy word wrap row breaker.
// Instantiates gwwb_front, gwwb_queue and gwwb_back; uses gwwb_pkg.
`default_nettype none

// One character request is taken per clock while full_o is low; the front
// updates the running row, word and last-space state in that cycle and
// stores a record of the rows it closes (zero, one or two) in a four-entry
// queue. The oldest row is driven on out_item_o from the registered queue head,
// and one row leaves per cycle on pop_i while empty_o is low, so a request
// that closes two rows takes two pops. full_o rises only when four records
// wait unread. wrap_width is written through the cfg channel, which is always
// ready; write it only while no request is in flight.
module greedy_word_wrap_breaker (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire gwwb_pkg::in_item_t          in_item_i,
  output logic                             full_o,
  output logic                             empty_o,
  input  wire logic                        pop_i,
  output gwwb_pkg::out_item_t              out_item_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [gwwb_pkg::LEN_W-1:0]  cfg_data_i
);

  logic                wr_en;
  gwwb_pkg::rec_t      wr_rec;
  logic                rd_en;
  gwwb_pkg::q_status_t q_status;

  assign cfg_ready_o = 1'b1;
  assign full_o      = q_status.full;

  gwwb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .in_item_i   (in_item_i),
    .full_i      (q_status.full),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .wr_en_o     (wr_en),
    .wr_rec_o    (wr_rec)
  );

  gwwb_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_rec_i (wr_rec),
    .rd_en_i  (rd_en),
    .status_o (q_status)
  );

  gwwb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (q_status),
    .pop_i      (pop_i),
    .rd_en_o    (rd_en),
    .empty_o    (empty_o),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

@@ hw/rtl/gwwb_checker.sv @@
// Port level checks for the greedy word wrap row breaker and their binding.
// Uses gwwb_pkg types; binds to greedy_word_wrap_breaker.
`default_nettype none

module gwwb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        push_i,
  input wire logic                        full_o,
  input wire logic                        empty_o,
  input wire logic                        pop_i,
  input wire gwwb_pkg::out_item_t         out_item_o
);

  // The final row of a text always closes its request's run.
  a_open_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && out_item_o.end_open) |-> out_item_o.last_of_run)
    else $error("open row not marked last of run");

  // The second row of a request follows right after the first is taken.
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !out_item_o.last_of_run && pop_i) |=>
      (!empty_o && out_item_o.last_of_run))
    else $error("run broken after first row");

  // No row appears without a request.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o)
    else $error("row appeared without request");

  // A waiting row holds while not taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_item_o)))
    else $error("waiting row changed");

endmodule

bind greedy_word_wrap_breaker gwwb_checker u_gwwb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push_i     (push_i),
  .full_o     (full_o),
  .empty_o    (empty_o),
  .pop_i      (pop_i),
  .out_item_o (out_item_o)
);

`default_nettype wire
